FILE: hdl/csvfs_pkg.sv
// csvfs_pkg: types and constants shared by the csv field splitter files
// no dependencies
package csvfs_pkg;

	localparam int unsigned FIELD_LIMIT = 255;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_DATA     = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_out;
		logic [7:0] field_index;
		logic [7:0] field_total;
		logic       truncated;
		logic       last;
	} res_t;

endpackage

FILE: hdl/csvfs_if.sv
// csvfs_in_if / csvfs_out_if: valid/ready channels of the csv field splitter
// depends on csvfs_pkg
interface csvfs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_end;

	modport source (output valid, output char_in, output line_end, input ready);
	modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface csvfs_out_if;
	logic              valid;
	logic              ready;
	csvfs_pkg::kind_t  kind;
	logic [7:0]        char_out;
	logic [7:0]        field_index;
	logic [7:0]        field_total;
	logic              truncated;
	logic              last;

	modport source (output valid, output kind, output char_out, output field_index,
		output field_total, output truncated, output last, input ready);
	modport sink (input valid, input kind, input char_out, input field_index,
		input field_total, input truncated, input last, output ready);
endinterface

FILE: hdl/csv_field_splitter.sv
// csv_field_splitter: splits a byte stream into comma separated fields with quote escapes
// depends on csvfs_pkg and the channel interfaces in csvfs_if.sv
// output: first result of a beat is registered and on the output in the cycle after the beat is accepted
// throughput: one input beat per cycle while the output is not stalled and each beat
//   yields at most one result; a beat that opens a field and carries its first byte yields
//   two results and holds off the next beat while the second waits in the one spill slot
//   behind the single output register; reset: parser at line start, field count zero, max_fields 255, output empty
module csv_field_splitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	csvfs_in_if.sink           line_in,
	csvfs_out_if.source        field_out
);
	import csvfs_pkg::*;

	logic [7:0] max_fields_q;
	logic       after_sep_q;
	logic       in_quotes_q;
	logic       quote_pend_q;
	logic [7:0] field_cnt_q;
	logic       limit_hit_q;

	logic       nxt_after_sep;
	logic       nxt_in_quotes;
	logic       nxt_quote_pend;
	logic [7:0] nxt_field_cnt;
	logic       nxt_limit_hit;

	res_t       res0;
	res_t       res1;
	logic [1:0] n_res;
	logic [7:0] lim;
	logic [7:0] c;
	logic       accept;

	res_t       out_q;
	logic       out_valid_q;
	res_t       pend_q;
	logic       pend_valid_q;

	assign c = line_in.char_in;
	assign lim = (FIELD_LIMIT < 256 && 8'(FIELD_LIMIT) < max_fields_q) ?
		8'(FIELD_LIMIT) : max_fields_q;

	assign line_in.ready = !pend_valid_q && (!out_valid_q || field_out.ready);
	assign accept = line_in.valid && line_in.ready;

	always_comb begin
		nxt_after_sep  = after_sep_q;
		nxt_in_quotes  = in_quotes_q;
		nxt_quote_pend = quote_pend_q;
		nxt_field_cnt  = field_cnt_q;
		nxt_limit_hit  = limit_hit_q;
		res0 = '0;
		res1 = '0;
		n_res = 2'd0;
		if (line_in.line_end) begin
			res0.kind        = KIND_LINE_END;
			res0.field_total = field_cnt_q;
			res0.truncated   = limit_hit_q;
			res0.last        = 1'b1;
			n_res = 2'd1;
			nxt_after_sep  = 1'b1;
			nxt_in_quotes  = 1'b0;
			nxt_quote_pend = 1'b0;
			nxt_field_cnt  = 8'd0;
			nxt_limit_hit  = 1'b0;
		end else if (!limit_hit_q) begin
			// default result: single data byte for the current field
			res0.kind        = KIND_DATA;
			res0.char_out    = c;
			res0.field_index = field_cnt_q - 8'd1;
			res0.last        = 1'b1;
			if (quote_pend_q) begin
				nxt_quote_pend = 1'b0;
				if (c == CHAR_QUOTE) begin
					n_res = 2'd1;
				end else begin
					nxt_in_quotes = 1'b0;
					if (c == CHAR_COMMA) begin
						nxt_after_sep = 1'b1;
					end else begin
						n_res = 2'd1;
					end
				end
			end else if (in_quotes_q) begin
				if (c == CHAR_QUOTE) begin
					nxt_quote_pend = 1'b1;
				end else begin
					n_res = 2'd1;
				end
			end else if (after_sep_q) begin
				if (field_cnt_q >= lim) begin
					nxt_limit_hit = 1'b1;
				end else begin
					res0 = '0;
					res0.kind        = KIND_START;
					res0.field_index = field_cnt_q;
					res0.last        = 1'b1;
					n_res = 2'd1;
					nxt_field_cnt = field_cnt_q + 8'd1;
					if (c == CHAR_QUOTE) begin
						nxt_in_quotes = 1'b1;
						nxt_after_sep = 1'b0;
					end else if (c != CHAR_COMMA) begin
						nxt_after_sep = 1'b0;
						res0.last        = 1'b0;
						res1.kind        = KIND_DATA;
						res1.char_out    = c;
						res1.field_index = field_cnt_q;
						res1.last        = 1'b1;
						n_res = 2'd2;
					end
				end
			end else begin
				if (c == CHAR_COMMA) begin
					nxt_after_sep = 1'b1;
				end else begin
					n_res = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= 8'd255;
			after_sep_q  <= 1'b1;
			in_quotes_q  <= 1'b0;
			quote_pend_q <= 1'b0;
			field_cnt_q  <= 8'd0;
			limit_hit_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_fields_q <= cfg_wdata;
			end
			if (accept) begin
				after_sep_q  <= nxt_after_sep;
				in_quotes_q  <= nxt_in_quotes;
				quote_pend_q <= nxt_quote_pend;
				field_cnt_q  <= nxt_field_cnt;
				limit_hit_q  <= nxt_limit_hit;
			end
		end
	end

	// output register and spill slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q  <= (n_res != 2'd0);
			pend_valid_q <= (n_res == 2'd2);
		end else if (out_valid_q && field_out.ready) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (out_valid_q && field_out.ready) begin
			out_q <= pend_q;
		end
	end

	assign field_out.valid       = out_valid_q;
	assign field_out.kind        = out_q.kind;
	assign field_out.char_out    = out_q.char_out;
	assign field_out.field_index = out_q.field_index;
	assign field_out.field_total = out_q.field_total;
	assign field_out.truncated   = out_q.truncated;
	assign field_out.last        = out_q.last;

	a_pend_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("spill slot full with output register empty");

	a_pend_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !line_in.ready)
		else $error("input taken while spill slot full");

	a_quote_state: assert property (@(posedge clk) disable iff (!arst_n)
		(quote_pend_q |-> in_quotes_q) and (in_quotes_q |-> !after_sep_q))
		else $error("inconsistent quote state");

	a_line_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_in.line_end) |=>
			(out_valid_q && out_q.kind == KIND_LINE_END && out_q.last && !pend_valid_q))
		else $error("line end beat did not yield a summary");

endmodule
